/* sv/fsc_pkg.sv */
// fsc_pkg: shared types and constants of the freeze-out surface cell
// no dependencies
package fsc_pkg;

   localparam int CSR_IDX_W = 3;
   localparam int DIV_LAT   = 33;

   localparam logic [CSR_IDX_W-1:0] CSR_FREEZE_TEMP = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CELL_DX     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CELL_DY     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_STEP   = 3'd3;

   localparam logic [23:0] FREEZE_TEMP_RST = 24'd157286;
   localparam logic [23:0] CELL_DX_RST     = 24'd65536;
   localparam logic [23:0] CELL_DY_RST     = 24'd65536;
   localparam logic [23:0] TIME_STEP_RST   = 24'd65536;

   typedef struct packed {
      logic [23:0] t_old_00;
      logic [23:0] t_old_01;
      logic [23:0] t_old_10;
      logic [23:0] t_old_11;
      logic [23:0] t_new_00;
      logic [23:0] t_new_01;
      logic [23:0] t_new_10;
      logic [23:0] t_new_11;
      logic [23:0] tau_mid;
   } fsc_req_type;

   typedef struct packed {
      logic               cross_t;
      logic               cross_x;
      logic               cross_y;
      logic               found;
      logic signed [31:0] grad_t;
      logic signed [31:0] grad_x;
      logic signed [31:0] grad_y;
      logic signed [31:0] omega_time;
      logic signed [31:0] omega_x;
      logic signed [31:0] omega_y;
   } fsc_rsp_type;

   typedef struct packed {
      logic [23:0] freeze_temp;
      logic [23:0] cell_dx;
      logic [23:0] cell_dy;
      logic [23:0] time_step;
   } fsc_cfg_type;

   typedef struct packed {
      logic signed [26:0] dt;
      logic signed [26:0] dx;
      logic signed [26:0] dy;
      logic               ct;
      logic               cx;
      logic               cy;
      logic [23:0]        tau;
   } fsc_cls_type;

   typedef struct packed {
      logic        ct;
      logic        cx;
      logic        cy;
      logic        tn;
      logic        xn;
      logic        yn;
      logic [25:0] at;
      logic [25:0] ax;
      logic [25:0] ay;
   } fsc_carry_type;

endpackage

/* sv/fsc_front.sv */
// fsc_front: face sums, differences and crossing flags of one cell
// depends on fsc_pkg
module fsc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  fsc_pkg::fsc_req_type req,
   input  logic [23:0]         freeze_temp,
   output logic                valid,
   output fsc_pkg::fsc_cls_type item
);

   logic                 valid_ff;
   fsc_pkg::fsc_cls_type item_ff;
   fsc_pkg::fsc_cls_type item_in;
   logic [25:0] stm, stp, sxm, sxp, sym, syp, f4;

   function automatic logic crosses(input logic [25:0] sp, input logic [25:0] sm,
                                    input logic [25:0] f);
      return (sp > f && sm < f) || (sp < f && sm > f);
   endfunction

   always_comb begin
      stm = 26'(req.t_old_00) + 26'(req.t_old_01) + 26'(req.t_old_10) + 26'(req.t_old_11);
      stp = 26'(req.t_new_00) + 26'(req.t_new_01) + 26'(req.t_new_10) + 26'(req.t_new_11);
      sxm = 26'(req.t_old_00) + 26'(req.t_new_00) + 26'(req.t_old_01) + 26'(req.t_new_01);
      sxp = 26'(req.t_old_10) + 26'(req.t_new_10) + 26'(req.t_old_11) + 26'(req.t_new_11);
      sym = 26'(req.t_old_00) + 26'(req.t_new_00) + 26'(req.t_old_10) + 26'(req.t_new_10);
      syp = 26'(req.t_old_01) + 26'(req.t_new_01) + 26'(req.t_old_11) + 26'(req.t_new_11);
      f4  = {freeze_temp, 2'b00};
      item_in.dt  = $signed({1'b0, stp}) - $signed({1'b0, stm});
      item_in.dx  = $signed({1'b0, sxp}) - $signed({1'b0, sxm});
      item_in.dy  = $signed({1'b0, syp}) - $signed({1'b0, sym});
      item_in.ct  = crosses(stp, stm, f4);
      item_in.cx  = crosses(sxp, sxm, f4);
      item_in.cy  = crosses(syp, sym, f4);
      item_in.tau = req.tau_mid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign valid = valid_ff;
   assign item  = item_ff;

endmodule

/* sv/fsc_queue.sv */
// fsc_queue: short fifo between classification and arithmetic
// depends on fsc_pkg
module fsc_queue #(
   parameter int DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  fsc_pkg::fsc_cls_type din,
   input  logic                 pop,
   output logic                 valid,
   output logic                 full,
   output fsc_pkg::fsc_cls_type dout
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   fsc_pkg::fsc_cls_type mem [0:DEPTH-1];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign valid   = (count_ff != '0);
   assign do_pop  = pop && valid;
   assign do_push = push && (!full || do_pop);
   assign dout    = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= din;
      end
   end

endmodule

/* sv/fsc_div.sv */
// fsc_div: pipelined restoring divider, one quotient bit per stage,
// saturating signed 32-bit result; depends on nothing
module fsc_div #(
   parameter int NUM_W = 36,
   parameter int DEN_W = 24
) (
   input  logic             clock,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   input  logic             neg,
   input  logic             nz,
   output logic [31:0]      res
);

   localparam int HI_W  = NUM_W - 32;
   localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

   logic [DEN_W-1:0] rem_ff [0:32];
   logic [DEN_W-1:0] den_ff [0:32];
   logic [31:0]      low_ff [0:32];
   logic [31:0]      quo_ff [0:32];
   logic             sat_ff [0:32];
   logic             neg_ff [0:32];
   logic             nz_ff  [0:32];
   logic [HI_W-1:0]  hi;
   logic             sat_in;

   assign hi     = num[NUM_W-1:32];
   assign sat_in = CMP_W'(hi) >= CMP_W'(den);

   always_ff @(posedge clock) begin
      rem_ff[0] <= sat_in ? '0 : DEN_W'(hi);
      den_ff[0] <= den;
      low_ff[0] <= num[31:0];
      quo_ff[0] <= '0;
      sat_ff[0] <= sat_in;
      neg_ff[0] <= neg;
      nz_ff[0]  <= nz;
   end

   for (genvar k = 1; k <= 32; k++) begin : g_stage
      logic [DEN_W:0]   trial;
      logic             ge;
      logic [DEN_W-1:0] rem_in;
      always_comb begin
         trial  = {rem_ff[k-1], low_ff[k-1][31]};
         ge     = trial >= {1'b0, den_ff[k-1]};
         rem_in = ge ? DEN_W'(trial - {1'b0, den_ff[k-1]}) : trial[DEN_W-1:0];
      end
      always_ff @(posedge clock) begin
         rem_ff[k] <= rem_in;
         den_ff[k] <= den_ff[k-1];
         low_ff[k] <= {low_ff[k-1][30:0], 1'b0};
         quo_ff[k] <= {quo_ff[k-1][30:0], ge};
         sat_ff[k] <= sat_ff[k-1];
         neg_ff[k] <= neg_ff[k-1];
         nz_ff[k]  <= nz_ff[k-1];
      end
   end

   always_comb begin
      if (!nz_ff[32]) begin
         res = '0;
      end else if (neg_ff[32]) begin
         res = (sat_ff[32] || quo_ff[32][31]) ? 32'h8000_0000 : 32'(-quo_ff[32]);
      end else begin
         res = (sat_ff[32] || quo_ff[32][31]) ? 32'h7FFF_FFFF : quo_ff[32];
      end
   end

endmodule

/* sv/fsc_back.sv */
// fsc_back: gradients, dominant direction and surface normal pipeline
// depends on fsc_pkg and fsc_div
module fsc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  fsc_pkg::fsc_cls_type in_item,
   input  fsc_pkg::fsc_cfg_type cfg,
   output logic                 out_valid,
   output fsc_pkg::fsc_rsp_type out_data
);

   localparam int LAT = fsc_pkg::DIV_LAT;

   logic                   v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   fsc_pkg::fsc_carry_type c1_ff, c2_ff, c3_ff, c4_ff, c5_ff, c6_ff;
   fsc_pkg::fsc_carry_type c1_in;
   logic [23:0]  tau1_ff;
   logic [26:0]  abs_t, abs_x, abs_y;

   // stage 2
   logic [49:0]  a2_ff, b2_ff, c2p_ff;
   logic [47:0]  pt1_ff, pt2_ff;
   // stage 3
   logic [49:0]  ahh_ff, ahl_ff, all_ff, bhh_ff, bhl_ff, bll_ff, chh_ff, chl_ff, cll_ff;
   logic [47:0]  q1h_ff, q1l_ff, q2h_ff, q2l_ff, q3h_ff, q3l_ff;
   logic         xdom3_ff, xdom4_ff;
   // stage 4
   logic [100:0] sqa_ff, sqb_ff, sqc_ff;
   logic [71:0]  pt_ff, px_ff, py_ff;
   // stage 5
   logic [49:0]  kt_ff [0:2];
   logic [49:0]  kx_ff [0:2];
   logic [49:0]  ky_ff [0:2];
   logic [25:0]  m5_ff, m6_ff, m5_in;
   logic         f5_ff, f6_ff, f5_in, tdom;
   // stage 6
   logic [65:0]  nt_ff, nx_ff, ny_ff;
   logic [97:0]  numt, numx, numy;

   logic         dly_v_ff [0:LAT-1];
   logic [3:0]   dly_f_ff [0:LAT-1];
   logic         out_valid_ff;
   fsc_pkg::fsc_rsp_type out_ff;
   logic [31:0]  r_gt, r_gx, r_gy, r_ot, r_ox, r_oy;

   always_comb begin
      abs_t = in_item.dt[26] ? 27'(-in_item.dt) : 27'(in_item.dt);
      abs_x = in_item.dx[26] ? 27'(-in_item.dx) : 27'(in_item.dx);
      abs_y = in_item.dy[26] ? 27'(-in_item.dy) : 27'(in_item.dy);
      c1_in.ct = in_item.ct;
      c1_in.cx = in_item.cx;
      c1_in.cy = in_item.cy;
      c1_in.tn = in_item.dt[26];
      c1_in.xn = in_item.dx[26];
      c1_in.yn = in_item.dy[26];
      c1_in.at = abs_t[25:0];
      c1_in.ax = abs_x[25:0];
      c1_in.ay = abs_y[25:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   // stage 1 to 4: products, squares and their sums
   always_ff @(posedge clock) begin
      c1_ff   <= c1_in;
      tau1_ff <= in_item.tau;

      c2_ff   <= c1_ff;
      a2_ff   <= 50'(c1_ff.at) * 50'(cfg.cell_dy);
      b2_ff   <= 50'(c1_ff.ax) * 50'(cfg.cell_dy);
      c2p_ff  <= 50'(c1_ff.ay) * 50'(cfg.cell_dx);
      pt1_ff  <= 48'(tau1_ff) * 48'(cfg.cell_dx);
      pt2_ff  <= 48'(tau1_ff) * 48'(cfg.time_step);

      c3_ff    <= c2_ff;
      ahh_ff   <= 50'(a2_ff[49:25]) * 50'(a2_ff[49:25]);
      ahl_ff   <= 50'(a2_ff[49:25]) * 50'(a2_ff[24:0]);
      all_ff   <= 50'(a2_ff[24:0]) * 50'(a2_ff[24:0]);
      bhh_ff   <= 50'(b2_ff[49:25]) * 50'(b2_ff[49:25]);
      bhl_ff   <= 50'(b2_ff[49:25]) * 50'(b2_ff[24:0]);
      bll_ff   <= 50'(b2_ff[24:0]) * 50'(b2_ff[24:0]);
      chh_ff   <= 50'(c2p_ff[49:25]) * 50'(c2p_ff[49:25]);
      chl_ff   <= 50'(c2p_ff[49:25]) * 50'(c2p_ff[24:0]);
      cll_ff   <= 50'(c2p_ff[24:0]) * 50'(c2p_ff[24:0]);
      xdom3_ff <= b2_ff > c2p_ff;
      q1h_ff   <= 48'(pt1_ff[47:24]) * 48'(cfg.cell_dy);
      q1l_ff   <= 48'(pt1_ff[23:0]) * 48'(cfg.cell_dy);
      q2h_ff   <= 48'(pt2_ff[47:24]) * 48'(cfg.cell_dy);
      q2l_ff   <= 48'(pt2_ff[23:0]) * 48'(cfg.cell_dy);
      q3h_ff   <= 48'(pt2_ff[47:24]) * 48'(cfg.cell_dx);
      q3l_ff   <= 48'(pt2_ff[23:0]) * 48'(cfg.cell_dx);

      c4_ff    <= c3_ff;
      xdom4_ff <= xdom3_ff;
      sqa_ff   <= (101'(ahh_ff) << 50) + (101'(ahl_ff) << 26) + 101'(all_ff);
      sqb_ff   <= (101'(bhh_ff) << 50) + (101'(bhl_ff) << 26) + 101'(bll_ff);
      sqc_ff   <= (101'(chh_ff) << 50) + (101'(chl_ff) << 26) + 101'(cll_ff);
      pt_ff    <= (72'(q1h_ff) << 24) + 72'(q1l_ff);
      px_ff    <= (72'(q2h_ff) << 24) + 72'(q2l_ff);
      py_ff    <= (72'(q3h_ff) << 24) + 72'(q3l_ff);
   end

   // stage 5: direction choice and partial products of the normal
   always_comb begin
      tdom = sqa_ff > (sqb_ff + sqc_ff);
      if (tdom) begin
         m5_in = c4_ff.at;
         f5_in = c4_ff.ct;
      end else if (xdom4_ff) begin
         m5_in = c4_ff.ax;
         f5_in = c4_ff.cx;
      end else begin
         m5_in = c4_ff.ay;
         f5_in = c4_ff.cy;
      end
      f5_in = f5_in && (m5_in != '0);
   end

   always_ff @(posedge clock) begin
      c5_ff <= c4_ff;
      m5_ff <= m5_in;
      f5_ff <= f5_in;
      for (int j = 0; j < 3; j++) begin
         kt_ff[j] <= 50'(pt_ff[24*j +: 24]) * 50'(c4_ff.at);
         kx_ff[j] <= 50'(px_ff[24*j +: 24]) * 50'(c4_ff.ax);
         ky_ff[j] <= 50'(py_ff[24*j +: 24]) * 50'(c4_ff.ay);
      end
   end

   // stage 6: full numerators, scaled down by 2^32 before the divide
   always_comb begin
      numt = (98'(kt_ff[2]) << 48) + (98'(kt_ff[1]) << 24) + 98'(kt_ff[0]);
      numx = (98'(kx_ff[2]) << 48) + (98'(kx_ff[1]) << 24) + 98'(kx_ff[0]);
      numy = (98'(ky_ff[2]) << 48) + (98'(ky_ff[1]) << 24) + 98'(ky_ff[0]);
   end

   always_ff @(posedge clock) begin
      c6_ff <= c5_ff;
      m6_ff <= m5_ff;
      f6_ff <= f5_ff;
      nt_ff <= numt[97:32];
      nx_ff <= numx[97:32];
      ny_ff <= numy[97:32];
   end

   fsc_div #(.NUM_W(36), .DEN_W(24)) u_div_gt (
      .clock(clock), .num({c6_ff.at, 10'b0}), .den(cfg.time_step),
      .neg(c6_ff.tn), .nz(c6_ff.at != '0), .res(r_gt));
   fsc_div #(.NUM_W(36), .DEN_W(24)) u_div_gx (
      .clock(clock), .num({c6_ff.ax, 10'b0}), .den(cfg.cell_dx),
      .neg(!c6_ff.xn && c6_ff.ax != '0), .nz(c6_ff.ax != '0), .res(r_gx));
   fsc_div #(.NUM_W(36), .DEN_W(24)) u_div_gy (
      .clock(clock), .num({c6_ff.ay, 10'b0}), .den(cfg.cell_dy),
      .neg(!c6_ff.yn && c6_ff.ay != '0), .nz(c6_ff.ay != '0), .res(r_gy));
   fsc_div #(.NUM_W(66), .DEN_W(26)) u_div_ot (
      .clock(clock), .num(nt_ff), .den(m6_ff),
      .neg(!c6_ff.tn && c6_ff.at != '0), .nz(f6_ff && c6_ff.at != '0), .res(r_ot));
   fsc_div #(.NUM_W(66), .DEN_W(26)) u_div_ox (
      .clock(clock), .num(nx_ff), .den(m6_ff),
      .neg(c6_ff.xn), .nz(f6_ff && c6_ff.ax != '0), .res(r_ox));
   fsc_div #(.NUM_W(66), .DEN_W(26)) u_div_oy (
      .clock(clock), .num(ny_ff), .den(m6_ff),
      .neg(c6_ff.yn), .nz(f6_ff && c6_ff.ay != '0), .res(r_oy));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < LAT; j++) begin
            dly_v_ff[j] <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else begin
         dly_v_ff[0] <= v6_ff;
         for (int j = 1; j < LAT; j++) begin
            dly_v_ff[j] <= dly_v_ff[j-1];
         end
         out_valid_ff <= dly_v_ff[LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      dly_f_ff[0] <= {c6_ff.ct, c6_ff.cx, c6_ff.cy, f6_ff};
      for (int j = 1; j < LAT; j++) begin
         dly_f_ff[j] <= dly_f_ff[j-1];
      end
      out_ff.cross_t    <= dly_f_ff[LAT-1][3];
      out_ff.cross_x    <= dly_f_ff[LAT-1][2];
      out_ff.cross_y    <= dly_f_ff[LAT-1][1];
      out_ff.found      <= dly_f_ff[LAT-1][0];
      out_ff.grad_t     <= r_gt;
      out_ff.grad_x     <= r_gx;
      out_ff.grad_y     <= r_gy;
      out_ff.omega_time <= r_ot;
      out_ff.omega_x    <= r_ox;
      out_ff.omega_y    <= r_oy;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

endmodule

/* sv/freezeout_surface_cell.sv */
// freezeout_surface_cell: top level, register file and front/queue/back wiring
// depends on fsc_pkg, fsc_front, fsc_queue, fsc_back
//
// One cell is taken per clock at any edge with start high and busy low; its
// result appears on rsp_data with rsp_strobe high for one cycle once it has
// passed the front register, the queue, six multiply and add stages and the
// 32-stage quotient pipelines. The arithmetic side drains the queue every
// cycle, so with QUEUE_DEPTH above one busy only rises during reset.
// Registers must be written while no cell is in flight.
module freezeout_surface_cell #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  fsc_pkg::fsc_req_type            req_data,
   output logic                            rsp_strobe,
   output fsc_pkg::fsc_rsp_type            rsp_data,
   input  logic                            csr_we,
   input  logic [fsc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [23:0]                     csr_wdata
);

   fsc_pkg::fsc_cfg_type cfg_ff;
   fsc_pkg::fsc_cls_type front_item, queue_item;
   logic front_valid, queue_valid, queue_full, accept;

   assign busy   = reset || queue_full;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.freeze_temp <= fsc_pkg::FREEZE_TEMP_RST;
         cfg_ff.cell_dx     <= fsc_pkg::CELL_DX_RST;
         cfg_ff.cell_dy     <= fsc_pkg::CELL_DY_RST;
         cfg_ff.time_step   <= fsc_pkg::TIME_STEP_RST;
      end else if (csr_we) begin
         case (csr_index)
            fsc_pkg::CSR_FREEZE_TEMP: cfg_ff.freeze_temp <= csr_wdata;
            fsc_pkg::CSR_CELL_DX:     cfg_ff.cell_dx     <= csr_wdata;
            fsc_pkg::CSR_CELL_DY:     cfg_ff.cell_dy     <= csr_wdata;
            fsc_pkg::CSR_TIME_STEP:   cfg_ff.time_step   <= csr_wdata;
            default: ;
         endcase
      end
   end

   fsc_front u_front (
      .clock(clock), .reset(reset), .accept(accept), .req(req_data),
      .freeze_temp(cfg_ff.freeze_temp), .valid(front_valid), .item(front_item));

   fsc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset), .push(front_valid), .din(front_item),
      .pop(1'b1), .valid(queue_valid), .full(queue_full), .dout(queue_item));

   fsc_back u_back (
      .clock(clock), .reset(reset), .in_valid(queue_valid), .in_item(queue_item),
      .cfg(cfg_ff), .out_valid(rsp_strobe), .out_data(rsp_data));

endmodule

/* sv/fsc_checker.sv */
// fsc_checker: port-level checks of the freeze-out surface cell
// depends on fsc_pkg; bound to freezeout_surface_cell
module fsc_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 busy,
   input logic                 rsp_strobe,
   input fsc_pkg::fsc_rsp_type rsp_data
);

   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_strobe)
      else $error("result transfer right after reset");

   a_found_needs_cross: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.found |->
         (rsp_data.cross_t || rsp_data.cross_x || rsp_data.cross_y))
      else $error("surface element without a crossing");

   a_no_omega_when_missing: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.found |->
         (rsp_data.omega_time == 0 && rsp_data.omega_x == 0 && rsp_data.omega_y == 0))
      else $error("normal nonzero without a surface element");

   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      !busy)
      else $error("busy outside reset");

endmodule

bind freezeout_surface_cell fsc_checker u_fsc_checker (
   .clock(clock), .reset(reset), .busy(busy),
   .rsp_strobe(rsp_strobe), .rsp_data(rsp_data));
